// ===== hdl/tsm_pkg.sv =====
// ----------------------------------------------------------------------------
// tsm_pkg
// Shared types and constants of the typed stack machine execution unit.
// ----------------------------------------------------------------------------
package tsm_pkg;

  localparam int STACK_DEPTH = 256;
  localparam int CALL_DEPTH  = 32;
  localparam int VALUE_W     = 32;
  localparam int PC_W        = 16;
  localparam int TAG_W       = 2;
  localparam int IMM_W       = 32;
  localparam int TGT_W       = 16;
  localparam int OP_W        = 5;
  localparam int STATUS_W    = 3;
  localparam int SP_W        = $clog2(STACK_DEPTH + 1);
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int DEPTH_W     = $clog2(CALL_DEPTH + 1);
  localparam int CS_ADDR_W   = $clog2(CALL_DEPTH);
  localparam int ENTRY_W     = VALUE_W + TAG_W;
  localparam int FRAME_W     = PC_W + SP_W;
  localparam int CNT_W       = $clog2(VALUE_W);
  localparam int POS_W       = IMM_W + 2;

  // Type tags
  localparam logic [TAG_W-1:0] TAG_INT   = 2'd0;
  localparam logic [TAG_W-1:0] TAG_CODE  = 2'd1;
  localparam logic [TAG_W-1:0] TAG_STACK = 2'd2;
  localparam logic [TAG_W-1:0] TAG_HEAP  = 2'd3;

  typedef enum logic [OP_W-1:0] {
    OP_PUSHI  = 5'd0,  OP_ADD    = 5'd1,  OP_SUB    = 5'd2,  OP_MUL    = 5'd3,
    OP_DIV    = 5'd4,  OP_MOD    = 5'd5,  OP_LT     = 5'd6,  OP_LE     = 5'd7,
    OP_GT     = 5'd8,  OP_GE     = 5'd9,  OP_NOT    = 5'd10, OP_EQUAL  = 5'd11,
    OP_PADD   = 5'd12, OP_SWAP   = 5'd13, OP_POPIMM = 5'd14, OP_POPN   = 5'd15,
    OP_PUSHN  = 5'd16, OP_PUSHG  = 5'd17, OP_PUSHL  = 5'd18, OP_STOREL = 5'd19,
    OP_STOREG = 5'd20, OP_PUSHSP = 5'd21, OP_PUSHFP = 5'd22, OP_PUSHGP = 5'd23,
    OP_JUMP   = 5'd24, OP_JZ     = 5'd25, OP_PUSHA  = 5'd26, OP_CALL   = 5'd27,
    OP_RETURN = 5'd28, OP_START  = 5'd29, OP_NOP    = 5'd30, OP_WRITE  = 5'd31
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_UNDERFLOW = 3'd1,
    ST_OVERFLOW  = 3'd2,
    ST_TYPE      = 3'd3,
    ST_CALL      = 3'd4,
    ST_DIVZERO   = 3'd5,
    ST_INDEX     = 3'd6
  } status_t;

  // Divider command
  typedef struct packed {
    logic start;
    logic want_mod;
  } div_cmd_t;

endpackage

// ===== hdl/tsm_if.sv =====
// ----------------------------------------------------------------------------
// tsm_req_if / tsm_rsp_if
// Valid/ready channels for instruction requests and step results.
// ----------------------------------------------------------------------------
interface tsm_req_if;
  logic                             valid;
  logic                             ready;
  logic [tsm_pkg::OP_W-1:0]         req_type;
  logic signed [tsm_pkg::IMM_W-1:0] imm;
  logic [tsm_pkg::TGT_W-1:0]        target;

  modport source (output valid, req_type, imm, target, input ready);
  modport sink   (input valid, req_type, imm, target, output ready);
endinterface

interface tsm_rsp_if;
  logic                               valid;
  logic                               ready;
  logic [tsm_pkg::STATUS_W-1:0]       status;
  logic signed [tsm_pkg::VALUE_W-1:0] top_value;
  logic [tsm_pkg::TAG_W-1:0]          top_type;
  logic                               stack_empty;
  logic [tsm_pkg::PC_W-1:0]           pc_out;
  logic [tsm_pkg::SP_W-1:0]           sp_out;
  logic [tsm_pkg::SP_W-1:0]           fp_out;
  logic                               write_valid;

  modport source (output valid, status, top_value, top_type, stack_empty, pc_out, sp_out,
                  fp_out, write_valid, input ready);
  modport sink   (input valid, status, top_value, top_type, stack_empty, pc_out, sp_out,
                  fp_out, write_valid, output ready);
endinterface

// ===== hdl/tsm_ram.sv =====
// ----------------------------------------------------------------------------
// tsm_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tsm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/tsm_div.sv =====
// ----------------------------------------------------------------------------
// tsm_div
// Radix-2 restoring signed divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module tsm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  tsm_pkg::div_cmd_t             cmd,
  input  logic [tsm_pkg::VALUE_W-1:0]   a,
  input  logic [tsm_pkg::VALUE_W-1:0]   b,
  output logic                          done,
  output logic [tsm_pkg::VALUE_W-1:0]   result
);

  logic                          busy;
  logic [tsm_pkg::CNT_W-1:0]     cnt;
  logic [tsm_pkg::VALUE_W-1:0]   quo;
  logic [tsm_pkg::VALUE_W-1:0]   rem;
  logic [tsm_pkg::VALUE_W-1:0]   ub;
  logic                          neg_a;
  logic                          neg_b;
  logic                          want_mod;
  logic [tsm_pkg::VALUE_W:0]     rem_sh;
  logic [tsm_pkg::VALUE_W:0]     diff;

  // Shift in the next dividend bit and trial subtract
  assign rem_sh = {rem, quo[tsm_pkg::VALUE_W-1]};
  assign diff   = rem_sh - {1'b0, ub};

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == tsm_pkg::CNT_W'(tsm_pkg::VALUE_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath on magnitudes
  always_ff @(posedge clk) begin
    if (cmd.start) begin
      neg_a    <= a[tsm_pkg::VALUE_W-1];
      neg_b    <= b[tsm_pkg::VALUE_W-1];
      want_mod <= cmd.want_mod;
      quo      <= a[tsm_pkg::VALUE_W-1] ? (~a + 1'b1) : a;
      ub       <= b[tsm_pkg::VALUE_W-1] ? (~b + 1'b1) : b;
      rem      <= '0;
    end else if (busy) begin
      if (!diff[tsm_pkg::VALUE_W]) begin
        rem <= diff[tsm_pkg::VALUE_W-1:0];
        quo <= {quo[tsm_pkg::VALUE_W-2:0], 1'b1};
      end else begin
        rem <= rem_sh[tsm_pkg::VALUE_W-1:0];
        quo <= {quo[tsm_pkg::VALUE_W-2:0], 1'b0};
      end
    end
  end

  // Restore signs: quotient by both, remainder by the dividend
  always_comb begin
    if (want_mod) begin
      result = neg_a ? (~rem + 1'b1) : rem;
    end else begin
      result = (neg_a != neg_b) ? (~quo + 1'b1) : quo;
    end
  end

endmodule

// ===== hdl/typed_stack_machine_exec.sv =====
// ----------------------------------------------------------------------------
// typed_stack_machine_exec
// Executes one typed stack-machine instruction per request.
//
// Each request is one instruction; one result follows it. A request is taken
// only while the unit is idle. The operand stack sits in a RAM with one write
// port and one registered read port, so an instruction walks a short sequence:
// read the top, read the second entry (or the addressed global/local), execute,
// write back one or two entries, then read the new top for the result. Swap
// writes two entries; an instruction that writes nothing or fails skips the
// write-back; div and mod wait for the bit-serial divider before it; pushn
// with count n writes one zero per cycle. The unit is ready again in the
// cycle after the result is taken. Errors leave all state unchanged. No
// clearing pass follows reset.
// ----------------------------------------------------------------------------
module typed_stack_machine_exec (
  input  logic            clk,
  input  logic            rst,
  tsm_req_if.sink         req,
  tsm_rsp_if.source       rsp
);

  typedef enum logic [10:0] {
    S_IDLE = 11'b00000000001,
    S_RA   = 11'b00000000010,
    S_RB   = 11'b00000000100,
    S_EXEC = 11'b00000001000,
    S_DIV  = 11'b00000010000,
    S_WR   = 11'b00000100000,
    S_WR2  = 11'b00001000000,
    S_FILL = 11'b00010000000,
    S_TRD  = 11'b00100000000,
    S_TCAP = 11'b01000000000,
    S_OUT  = 11'b10000000000
  } state_t;

  state_t state;

  // Request and architectural registers
  tsm_pkg::op_t                      op;
  logic [tsm_pkg::IMM_W-1:0]         imm;
  logic [tsm_pkg::TGT_W-1:0]         tgt;
  logic [tsm_pkg::SP_W-1:0]          sp;
  logic [tsm_pkg::SP_W-1:0]          fp;
  logic [tsm_pkg::PC_W-1:0]          pc;
  logic [tsm_pkg::DEPTH_W-1:0]       depth;
  logic [tsm_pkg::VALUE_W-1:0]       topv;
  logic [tsm_pkg::TAG_W-1:0]         topt;

  // Write plan
  logic                              w2_en;
  logic [tsm_pkg::ADDR_W-1:0]        w1_addr;
  logic [tsm_pkg::ENTRY_W-1:0]       w1_data;
  logic [tsm_pkg::ADDR_W-1:0]        w2_addr;
  logic [tsm_pkg::ENTRY_W-1:0]       w2_data;
  logic [tsm_pkg::SP_W-1:0]          fill_cnt;

  // Result registers
  tsm_pkg::status_t                  out_status;
  logic                              out_wv;
  logic [tsm_pkg::VALUE_W-1:0]       out_value;
  logic [tsm_pkg::TAG_W-1:0]         out_tag;

  // Memories
  logic                              stk_we;
  logic [tsm_pkg::ADDR_W-1:0]        stk_waddr;
  logic [tsm_pkg::ENTRY_W-1:0]       stk_wdata;
  logic [tsm_pkg::ADDR_W-1:0]        stk_raddr;
  logic [tsm_pkg::ENTRY_W-1:0]       stk_rdata;
  logic                              cs_we;
  logic [tsm_pkg::CS_ADDR_W-1:0]     cs_waddr;
  logic [tsm_pkg::FRAME_W-1:0]       cs_wdata;
  logic [tsm_pkg::CS_ADDR_W-1:0]     cs_raddr;
  logic [tsm_pkg::FRAME_W-1:0]       cs_rdata;

  // Divider
  tsm_pkg::div_cmd_t                 div_cmd;
  logic                              div_done;
  logic [tsm_pkg::VALUE_W-1:0]       div_result;

  // Helpers
  logic [tsm_pkg::VALUE_W-1:0]       sv;
  logic [tsm_pkg::TAG_W-1:0]         stt;
  logic [tsm_pkg::SP_W-1:0]          sp_m1;
  logic [tsm_pkg::SP_W-1:0]          sp_m2;
  logic [tsm_pkg::SP_W-1:0]          room;
  logic [tsm_pkg::DEPTH_W-1:0]       depth_m1;
  logic [tsm_pkg::PC_W-1:0]          pc_p1;
  logic                              has1;
  logic                              has2;
  logic                              full;
  logic                              imm_pos;
  logic                              top_pos;
  logic                              is_local;
  logic signed [tsm_pkg::POS_W-1:0]  pos;
  logic signed [tsm_pkg::POS_W-1:0]  sp_s;

  // Execute results
  tsm_pkg::status_t                  ex_st;
  logic [tsm_pkg::SP_W-1:0]          ex_sp;
  logic [tsm_pkg::SP_W-1:0]          ex_fp;
  logic [tsm_pkg::PC_W-1:0]          ex_pc;
  logic [tsm_pkg::DEPTH_W-1:0]       ex_depth;
  logic                              ex_w1;
  logic [tsm_pkg::ADDR_W-1:0]        ex_w1_addr;
  logic [tsm_pkg::ENTRY_W-1:0]       ex_w1_data;
  logic                              ex_w2;
  logic [tsm_pkg::ADDR_W-1:0]        ex_w2_addr;
  logic [tsm_pkg::ENTRY_W-1:0]       ex_w2_data;
  logic                              ex_wv;
  logic                              ex_fill;
  logic                              ex_div;
  logic                              ex_call;

  assign sv       = stk_rdata[tsm_pkg::VALUE_W-1:0];
  assign stt      = stk_rdata[tsm_pkg::ENTRY_W-1:tsm_pkg::VALUE_W];
  assign sp_m1    = sp - 1'b1;
  assign sp_m2    = sp - 2'd2;
  assign room     = tsm_pkg::SP_W'(tsm_pkg::STACK_DEPTH) - sp;
  assign depth_m1 = depth - 1'b1;
  assign pc_p1    = pc + 1'b1;
  assign has1     = (sp != '0);
  assign has2     = (sp >= tsm_pkg::SP_W'(2));
  assign full     = (sp >= tsm_pkg::SP_W'(tsm_pkg::STACK_DEPTH));
  assign imm_pos  = !imm[tsm_pkg::IMM_W-1] && (imm != '0);
  assign top_pos  = !topv[tsm_pkg::VALUE_W-1] && (topv != '0);
  assign is_local = (op == tsm_pkg::OP_PUSHL) || (op == tsm_pkg::OP_STOREL);

  // Absolute stack position for globals and locals
  assign pos  = $signed(tsm_pkg::POS_W'(is_local ? fp : '0)) +
                $signed(tsm_pkg::POS_W'($signed(imm)));
  assign sp_s = $signed(tsm_pkg::POS_W'(sp));

  tsm_ram #(
    .WIDTH (tsm_pkg::ENTRY_W),
    .DEPTH (tsm_pkg::STACK_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (stk_we),
    .waddr (stk_waddr),
    .wdata (stk_wdata),
    .raddr (stk_raddr),
    .rdata (stk_rdata)
  );

  tsm_ram #(
    .WIDTH (tsm_pkg::FRAME_W),
    .DEPTH (tsm_pkg::CALL_DEPTH)
  ) u_calls (
    .clk   (clk),
    .we    (cs_we),
    .waddr (cs_waddr),
    .wdata (cs_wdata),
    .raddr (cs_raddr),
    .rdata (cs_rdata)
  );

  tsm_div u_div (
    .clk    (clk),
    .rst    (rst),
    .cmd    (div_cmd),
    .a      (sv),
    .b      (topv),
    .done   (div_done),
    .result (div_result)
  );

  // Stack read address per step
  always_comb begin
    unique case (state)
      S_RB: begin
        if (op == tsm_pkg::OP_PUSHG || op == tsm_pkg::OP_PUSHL) begin
          stk_raddr = pos[tsm_pkg::ADDR_W-1:0];
        end else begin
          stk_raddr = sp_m2[tsm_pkg::ADDR_W-1:0];
        end
      end
      default: stk_raddr = sp_m1[tsm_pkg::ADDR_W-1:0];
    endcase
  end

  // Stack write port
  always_comb begin
    stk_we    = 1'b0;
    stk_waddr = w1_addr;
    stk_wdata = w1_data;
    unique case (state)
      S_WR:   stk_we = 1'b1;
      S_WR2: begin
        stk_we    = 1'b1;
        stk_waddr = w2_addr;
        stk_wdata = w2_data;
      end
      S_FILL: begin
        stk_we    = 1'b1;
        stk_wdata = '0;
      end
      default: stk_we = 1'b0;
    endcase
  end

  // Call stack: push in execute, always read the current top frame
  assign cs_raddr = depth_m1[tsm_pkg::CS_ADDR_W-1:0];
  assign cs_we    = (state == S_EXEC) && ex_call;
  assign cs_waddr = depth[tsm_pkg::CS_ADDR_W-1:0];
  assign cs_wdata = {pc_p1, fp};

  assign div_cmd.start    = (state == S_EXEC) && ex_div;
  assign div_cmd.want_mod = (op == tsm_pkg::OP_MOD);

  // Execute: check and compute the new state
  always_comb begin
    ex_st      = tsm_pkg::ST_OK;
    ex_sp      = sp;
    ex_fp      = fp;
    ex_pc      = pc_p1;
    ex_depth   = depth;
    ex_w1      = 1'b0;
    ex_w1_addr = sp[tsm_pkg::ADDR_W-1:0];
    ex_w1_data = '0;
    ex_w2      = 1'b0;
    ex_w2_addr = sp_m2[tsm_pkg::ADDR_W-1:0];
    ex_w2_data = {topt, topv};
    ex_wv      = 1'b0;
    ex_fill    = 1'b0;
    ex_div     = 1'b0;
    ex_call    = 1'b0;
    unique case (op) inside
      tsm_pkg::OP_PUSHI: begin
        if (full) begin
          ex_st = tsm_pkg::ST_OVERFLOW;
        end else begin
          ex_w1      = 1'b1;
          ex_w1_data = {tsm_pkg::TAG_INT, imm};
          ex_sp      = sp + 1'b1;
        end
      end
      tsm_pkg::OP_ADD, tsm_pkg::OP_SUB, tsm_pkg::OP_MUL, tsm_pkg::OP_DIV,
      tsm_pkg::OP_MOD, tsm_pkg::OP_LT, tsm_pkg::OP_LE, tsm_pkg::OP_GT,
      tsm_pkg::OP_GE: begin
        ex_w1_addr = sp_m2[tsm_pkg::ADDR_W-1:0];
        if (!has2) begin
          ex_st = tsm_pkg::ST_UNDERFLOW;
        end else if (topt != tsm_pkg::TAG_INT || stt != tsm_pkg::TAG_INT) begin
          ex_st = tsm_pkg::ST_TYPE;
        end else if ((op == tsm_pkg::OP_DIV || op == tsm_pkg::OP_MOD) && topv == '0) begin
          ex_st = tsm_pkg::ST_DIVZERO;
        end else begin
          ex_w1 = 1'b1;
          ex_sp = sp_m1;
          case (op)
            tsm_pkg::OP_ADD: ex_w1_data = {tsm_pkg::TAG_INT, sv + topv};
            tsm_pkg::OP_SUB: ex_w1_data = {tsm_pkg::TAG_INT, sv - topv};
            tsm_pkg::OP_MUL: ex_w1_data = {tsm_pkg::TAG_INT, tsm_pkg::VALUE_W'(sv * topv)};
            tsm_pkg::OP_LT: ex_w1_data = {tsm_pkg::TAG_INT,
                                          tsm_pkg::VALUE_W'($signed(sv) < $signed(topv))};
            tsm_pkg::OP_LE: ex_w1_data = {tsm_pkg::TAG_INT,
                                          tsm_pkg::VALUE_W'($signed(sv) <= $signed(topv))};
            tsm_pkg::OP_GT: ex_w1_data = {tsm_pkg::TAG_INT,
                                          tsm_pkg::VALUE_W'($signed(sv) > $signed(topv))};
            tsm_pkg::OP_GE: ex_w1_data = {tsm_pkg::TAG_INT,
                                          tsm_pkg::VALUE_W'($signed(sv) >= $signed(topv))};
            default: ex_div = 1'b1;
          endcase
        end
      end
      tsm_pkg::OP_NOT: begin
        if (!has1) begin
          ex_st = tsm_pkg::ST_UNDERFLOW;
        end else begin
          ex_w1      = 1'b1;
          ex_w1_addr = sp_m1[tsm_pkg::ADDR_W-1:0];
          ex_w1_data = {tsm_pkg::TAG_INT, tsm_pkg::VALUE_W'(topv == '0)};
        end
      end
      tsm_pkg::OP_EQUAL: begin
        if (!has2) begin
          ex_st = tsm_pkg::ST_UNDERFLOW;
        end else begin
          ex_w1      = 1'b1;
          ex_w1_addr = sp_m2[tsm_pkg::ADDR_W-1:0];
          ex_w1_data = {tsm_pkg::TAG_INT, tsm_pkg::VALUE_W'(topt == stt && topv == sv)};
          ex_sp      = sp_m1;
        end
      end
      tsm_pkg::OP_PADD: begin
        if (!has2) begin
          ex_st = tsm_pkg::ST_UNDERFLOW;
        end else if (stt != tsm_pkg::TAG_INT || topt == tsm_pkg::TAG_INT) begin
          ex_st = tsm_pkg::ST_TYPE;
        end else begin
          ex_w1      = 1'b1;
          ex_w1_addr = sp_m2[tsm_pkg::ADDR_W-1:0];
          ex_w1_data = {topt, sv + topv};
          ex_sp      = sp_m1;
        end
      end
      tsm_pkg::OP_SWAP: begin
        if (!has2) begin
          ex_st = tsm_pkg::ST_UNDERFLOW;
        end else begin
          ex_w1      = 1'b1;
          ex_w1_addr = sp_m1[tsm_pkg::ADDR_W-1:0];
          ex_w1_data = stk_rdata;
          ex_w2      = 1'b1;
        end
      end
      tsm_pkg::OP_POPIMM: begin
        if (imm_pos) begin
          if (imm > tsm_pkg::IMM_W'(sp)) begin
            ex_st = tsm_pkg::ST_UNDERFLOW;
          end else begin
            ex_sp = sp - imm[tsm_pkg::SP_W-1:0];
          end
        end
      end
      tsm_pkg::OP_POPN: begin
        if (!has1) begin
          ex_st = tsm_pkg::ST_UNDERFLOW;
        end else if (topt != tsm_pkg::TAG_INT) begin
          ex_st = tsm_pkg::ST_TYPE;
        end else if (top_pos && topv > tsm_pkg::VALUE_W'(sp_m1)) begin
          ex_st = tsm_pkg::ST_UNDERFLOW;
        end else begin
          ex_sp = sp_m1 - (top_pos ? topv[tsm_pkg::SP_W-1:0] : '0);
        end
      end
      tsm_pkg::OP_PUSHN: begin
        if (imm_pos) begin
          if (imm > tsm_pkg::IMM_W'(room)) begin
            ex_st = tsm_pkg::ST_OVERFLOW;
          end else begin
            ex_fill = 1'b1;
            ex_sp   = sp + imm[tsm_pkg::SP_W-1:0];
          end
        end
      end
      tsm_pkg::OP_PUSHG, tsm_pkg::OP_PUSHL: begin
        if (pos < 0 || pos >= sp_s) begin
          ex_st = tsm_pkg::ST_INDEX;
        end else if (full) begin
          ex_st = tsm_pkg::ST_OVERFLOW;
        end else begin
          ex_w1      = 1'b1;
          ex_w1_data = stk_rdata;
          ex_sp      = sp + 1'b1;
        end
      end
      tsm_pkg::OP_STOREL, tsm_pkg::OP_STOREG: begin
        if (!has1) begin
          ex_st = tsm_pkg::ST_UNDERFLOW;
        end else if (pos < 0 || pos >= sp_s - 1) begin
          ex_st = tsm_pkg::ST_INDEX;
        end else begin
          ex_w1      = 1'b1;
          ex_w1_addr = pos[tsm_pkg::ADDR_W-1:0];
          ex_w1_data = {topt, topv};
          ex_sp      = sp_m1;
        end
      end
      tsm_pkg::OP_PUSHSP, tsm_pkg::OP_PUSHFP, tsm_pkg::OP_PUSHGP: begin
        if (full) begin
          ex_st = tsm_pkg::ST_OVERFLOW;
        end else begin
          ex_w1 = 1'b1;
          ex_sp = sp + 1'b1;
          if (op == tsm_pkg::OP_PUSHSP) begin
            ex_w1_data = {tsm_pkg::TAG_STACK, tsm_pkg::VALUE_W'(sp)};
          end else if (op == tsm_pkg::OP_PUSHFP) begin
            ex_w1_data = {tsm_pkg::TAG_STACK, tsm_pkg::VALUE_W'(fp)};
          end else begin
            ex_w1_data = {tsm_pkg::TAG_STACK, {tsm_pkg::VALUE_W{1'b0}}};
          end
        end
      end
      tsm_pkg::OP_JUMP: ex_pc = tsm_pkg::PC_W'(tgt);
      tsm_pkg::OP_JZ: begin
        if (!has1) begin
          ex_st = tsm_pkg::ST_UNDERFLOW;
        end else if (topt != tsm_pkg::TAG_INT) begin
          ex_st = tsm_pkg::ST_TYPE;
        end else begin
          ex_sp = sp_m1;
          if (topv == '0) begin
            ex_pc = tsm_pkg::PC_W'(tgt);
          end
        end
      end
      tsm_pkg::OP_PUSHA: begin
        if (full) begin
          ex_st = tsm_pkg::ST_OVERFLOW;
        end else begin
          ex_w1      = 1'b1;
          ex_w1_data = {tsm_pkg::TAG_CODE, tsm_pkg::VALUE_W'(tgt)};
          ex_sp      = sp + 1'b1;
        end
      end
      tsm_pkg::OP_CALL: begin
        if (!has1) begin
          ex_st = tsm_pkg::ST_UNDERFLOW;
        end else if (topt != tsm_pkg::TAG_CODE) begin
          ex_st = tsm_pkg::ST_TYPE;
        end else if (depth >= tsm_pkg::DEPTH_W'(tsm_pkg::CALL_DEPTH)) begin
          ex_st = tsm_pkg::ST_CALL;
        end else begin
          ex_call  = 1'b1;
          ex_depth = depth + 1'b1;
          ex_pc    = topv[tsm_pkg::PC_W-1:0];
          ex_sp    = sp_m1;
          ex_fp    = sp_m1;
        end
      end
      tsm_pkg::OP_RETURN: begin
        if (depth == '0) begin
          ex_st = tsm_pkg::ST_CALL;
        end else begin
          ex_depth = depth_m1;
          ex_sp    = fp;
          ex_pc    = cs_rdata[tsm_pkg::FRAME_W-1:tsm_pkg::SP_W];
          ex_fp    = cs_rdata[tsm_pkg::SP_W-1:0];
        end
      end
      tsm_pkg::OP_START: ex_fp = sp;
      tsm_pkg::OP_NOP:   ex_pc = pc;
      default: begin
        if (!has1) begin
          ex_st = tsm_pkg::ST_UNDERFLOW;
        end else begin
          ex_sp = sp_m1;
          ex_wv = 1'b1;
        end
      end
    endcase
  end

  // Sequencer and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sp    <= '0;
      fp    <= '0;
      pc    <= '0;
      depth <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (req.valid) begin
            state <= S_RA;
          end
        end
        S_RA: state <= S_RB;
        S_RB: state <= S_EXEC;
        S_EXEC: begin
          if (ex_st == tsm_pkg::ST_OK) begin
            sp    <= ex_sp;
            fp    <= ex_fp;
            pc    <= ex_pc;
            depth <= ex_depth;
          end
          if (ex_st != tsm_pkg::ST_OK) begin
            state <= S_TRD;
          end else if (ex_div) begin
            state <= S_DIV;
          end else if (ex_fill) begin
            state <= S_FILL;
          end else if (ex_w1) begin
            state <= S_WR;
          end else begin
            state <= S_TRD;
          end
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_WR;
          end
        end
        S_WR: state <= w2_en ? S_WR2 : S_TRD;
        S_WR2: state <= S_TRD;
        S_FILL: begin
          if (fill_cnt == tsm_pkg::SP_W'(1)) begin
            state <= S_TRD;
          end
        end
        S_TRD: state <= S_TCAP;
        S_TCAP: state <= S_OUT;
        S_OUT: begin
          if (rsp.ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        op  <= tsm_pkg::op_t'(req.req_type);
        imm <= req.imm;
        tgt <= req.target;
      end
      S_RB: begin
        topv <= sv;
        topt <= stt;
      end
      S_EXEC: begin
        out_status <= ex_st;
        out_wv     <= ex_wv && (ex_st == tsm_pkg::ST_OK);
        w1_addr    <= ex_w1_addr;
        w1_data    <= ex_w1_data;
        w2_en      <= ex_w2;
        w2_addr    <= ex_w2_addr;
        w2_data    <= ex_w2_data;
        fill_cnt   <= imm[tsm_pkg::SP_W-1:0];
      end
      S_DIV: w1_data <= {tsm_pkg::TAG_INT, div_result};
      S_FILL: begin
        w1_addr  <= w1_addr + 1'b1;
        fill_cnt <= fill_cnt - 1'b1;
      end
      S_TCAP: begin
        if (out_wv) begin
          out_value <= topv;
          out_tag   <= topt;
        end else if (sp == '0) begin
          out_value <= '0;
          out_tag   <= tsm_pkg::TAG_INT;
        end else begin
          out_value <= sv;
          out_tag   <= stt;
        end
      end
      default: ;
    endcase
  end

  // Channel ports
  assign req.ready       = (state == S_IDLE);
  assign rsp.valid       = (state == S_OUT);
  assign rsp.status      = out_status;
  assign rsp.top_value   = out_value;
  assign rsp.top_type    = out_tag;
  assign rsp.stack_empty = (sp == '0);
  assign rsp.pc_out      = pc;
  assign rsp.sp_out      = sp;
  assign rsp.fp_out      = fp;
  assign rsp.write_valid = out_wv;

  a_one_side: assert property (@(posedge clk) disable iff (rst)
    !(req.ready && rsp.valid))
    else $error("request and result sides active together");

  a_sp_range: assert property (@(posedge clk) disable iff (rst)
    sp <= tsm_pkg::SP_W'(tsm_pkg::STACK_DEPTH))
    else $error("stack pointer beyond stack depth");

  a_depth_range: assert property (@(posedge clk) disable iff (rst)
    depth <= tsm_pkg::DEPTH_W'(tsm_pkg::CALL_DEPTH))
    else $error("call depth beyond call stack");

  a_err_no_write: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && out_status != tsm_pkg::ST_OK |-> !out_wv)
    else $error("write flagged on failed step");

  a_err_holds_sp: assert property (@(posedge clk) disable iff (rst)
    state == S_EXEC && ex_st != tsm_pkg::ST_OK |=> $stable(sp) && $stable(pc))
    else $error("failed step changed state");

endmodule

// ===== tb/sv/tb_typed_stack_machine_exec.sv =====
// ----------------------------------------------------------------------------
// tb_typed_stack_machine_exec
// Self-checking testbench for the typed stack machine execution unit.
// A queue of instruction requests (directed corner cases, then random
// instruction sequences) feeds a clocked driver. Every accepted request runs
// through a local behavioral predictor of the unit, and the clocked monitor
// compares each step result field by field against the oldest prediction.
// Both channels idle and stall at random, in several phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_typed_stack_machine_exec;

  localparam int NUM_ITEMS = 560;
  localparam int IDLE_LIMIT = 20000;

  typedef struct {
    tsm_pkg::op_t op;
    logic [31:0]  imm;
    logic [15:0]  tgt;
  } instr_t;

  typedef struct {
    tsm_pkg::status_t status;
    logic [31:0]      top_value;
    logic [1:0]       top_type;
    logic             stack_empty;
    logic [15:0]      pc;
    logic [8:0]       sp;
    logic [8:0]       fp;
    logic             write_valid;
  } step_res_t;

  logic clk;
  logic rst;

  tsm_req_if req_ch ();
  tsm_rsp_if rsp_ch ();

  typed_stack_machine_exec uut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch)
  );

  // Machine state as the predictor sees it
  logic [31:0] stk_val [tsm_pkg::STACK_DEPTH];
  logic [1:0]  stk_tag [tsm_pkg::STACK_DEPTH];
  logic [15:0] ret_pc [tsm_pkg::CALL_DEPTH];
  int          ret_fp [tsm_pkg::CALL_DEPTH];
  int          depth;
  logic [15:0] pc_r;
  int          sp_r;
  int          fp_r;

  instr_t    pending_q [$];
  step_res_t expected_q [$];
  instr_t    cur_instr;
  int        accepted;
  int        errors;
  int        idle_cycles;
  int        send_idle;
  int        recv_stall;

  // Clock
  always begin
    clk = 1'b1;
    #2;
    clk = 1'b0;
    #2;
  end

  // Execute one instruction on the predictor state and return its result
  task automatic execute_step(input instr_t it, output step_res_t res);
    longint           simm;
    longint           pos;
    longint           n;
    longint           la;
    longint           lb;
    logic [31:0]      a;
    logic [31:0]      b;
    logic [31:0]      r;
    logic [1:0]       t;
    logic [15:0]      npc;
    int               nsp;
    int               nfp;
    tsm_pkg::status_t st;
    logic             wv;
    logic [31:0]      wval;
    logic [1:0]       wtag;
    simm = longint'($signed(it.imm));
    nsp  = sp_r;
    nfp  = fp_r;
    npc  = pc_r + 16'd1;
    st   = tsm_pkg::ST_OK;
    wv   = 1'b0;
    wval = '0;
    wtag = tsm_pkg::TAG_INT;
    case (it.op)
      tsm_pkg::OP_PUSHI: begin
        if (nsp >= tsm_pkg::STACK_DEPTH) st = tsm_pkg::ST_OVERFLOW;
        else begin
          stk_val[nsp] = it.imm; stk_tag[nsp] = tsm_pkg::TAG_INT; nsp++;
        end
      end
      tsm_pkg::OP_ADD, tsm_pkg::OP_SUB, tsm_pkg::OP_MUL, tsm_pkg::OP_DIV,
      tsm_pkg::OP_MOD, tsm_pkg::OP_LT, tsm_pkg::OP_LE, tsm_pkg::OP_GT,
      tsm_pkg::OP_GE: begin
        if (nsp < 2) st = tsm_pkg::ST_UNDERFLOW;
        else if (stk_tag[nsp-1] != tsm_pkg::TAG_INT ||
                 stk_tag[nsp-2] != tsm_pkg::TAG_INT) st = tsm_pkg::ST_TYPE;
        else begin
          a  = stk_val[nsp-2];
          b  = stk_val[nsp-1];
          la = longint'($signed(a));
          lb = longint'($signed(b));
          if ((it.op == tsm_pkg::OP_DIV || it.op == tsm_pkg::OP_MOD) && b == 0)
            st = tsm_pkg::ST_DIVZERO;
          else begin
            case (it.op)
              tsm_pkg::OP_ADD: r = a + b;
              tsm_pkg::OP_SUB: r = a - b;
              tsm_pkg::OP_MUL: r = a * b;
              tsm_pkg::OP_DIV: r = 32'(la / lb);
              tsm_pkg::OP_MOD: r = 32'(la % lb);
              tsm_pkg::OP_LT:  r = {31'd0, la < lb};
              tsm_pkg::OP_LE:  r = {31'd0, la <= lb};
              tsm_pkg::OP_GT:  r = {31'd0, la > lb};
              default: r = {31'd0, la >= lb};
            endcase
            nsp -= 2;
            stk_val[nsp] = r; stk_tag[nsp] = tsm_pkg::TAG_INT; nsp++;
          end
        end
      end
      tsm_pkg::OP_NOT: begin
        if (nsp < 1) st = tsm_pkg::ST_UNDERFLOW;
        else begin
          stk_val[nsp-1] = {31'd0, stk_val[nsp-1] == 0};
          stk_tag[nsp-1] = tsm_pkg::TAG_INT;
        end
      end
      tsm_pkg::OP_EQUAL: begin
        if (nsp < 2) st = tsm_pkg::ST_UNDERFLOW;
        else begin
          r = {31'd0, stk_tag[nsp-1] == stk_tag[nsp-2] && stk_val[nsp-1] == stk_val[nsp-2]};
          nsp -= 2;
          stk_val[nsp] = r; stk_tag[nsp] = tsm_pkg::TAG_INT; nsp++;
        end
      end
      tsm_pkg::OP_PADD: begin
        if (nsp < 2) st = tsm_pkg::ST_UNDERFLOW;
        else if (stk_tag[nsp-2] != tsm_pkg::TAG_INT ||
                 stk_tag[nsp-1] == tsm_pkg::TAG_INT) st = tsm_pkg::ST_TYPE;
        else begin
          t = stk_tag[nsp-1];
          r = stk_val[nsp-1] + stk_val[nsp-2];
          nsp -= 2;
          stk_val[nsp] = r; stk_tag[nsp] = t; nsp++;
        end
      end
      tsm_pkg::OP_SWAP: begin
        if (nsp < 2) st = tsm_pkg::ST_UNDERFLOW;
        else begin
          r = stk_val[nsp-1]; t = stk_tag[nsp-1];
          stk_val[nsp-1] = stk_val[nsp-2]; stk_tag[nsp-1] = stk_tag[nsp-2];
          stk_val[nsp-2] = r; stk_tag[nsp-2] = t;
        end
      end
      tsm_pkg::OP_POPIMM: begin
        if (simm > 0) begin
          if (simm > nsp) st = tsm_pkg::ST_UNDERFLOW;
          else nsp -= int'(simm);
        end
      end
      tsm_pkg::OP_POPN: begin
        if (nsp < 1) st = tsm_pkg::ST_UNDERFLOW;
        else if (stk_tag[nsp-1] != tsm_pkg::TAG_INT) st = tsm_pkg::ST_TYPE;
        else begin
          n = longint'($signed(stk_val[nsp-1]));
          if (n > 0 && n > nsp - 1) st = tsm_pkg::ST_UNDERFLOW;
          else begin
            nsp -= 1;
            if (n > 0) nsp -= int'(n);
          end
        end
      end
      tsm_pkg::OP_PUSHN: begin
        if (simm > 0) begin
          if (simm > tsm_pkg::STACK_DEPTH - nsp) st = tsm_pkg::ST_OVERFLOW;
          else begin
            for (int i = 0; i < simm; i++) begin
              stk_val[nsp] = '0; stk_tag[nsp] = tsm_pkg::TAG_INT; nsp++;
            end
          end
        end
      end
      tsm_pkg::OP_PUSHG, tsm_pkg::OP_PUSHL: begin
        pos = (it.op == tsm_pkg::OP_PUSHG ? 0 : fp_r) + simm;
        if (pos < 0 || pos >= nsp) st = tsm_pkg::ST_INDEX;
        else if (nsp >= tsm_pkg::STACK_DEPTH) st = tsm_pkg::ST_OVERFLOW;
        else begin
          stk_val[nsp] = stk_val[pos]; stk_tag[nsp] = stk_tag[pos]; nsp++;
        end
      end
      tsm_pkg::OP_STOREL, tsm_pkg::OP_STOREG: begin
        pos = (it.op == tsm_pkg::OP_STOREG ? 0 : fp_r) + simm;
        if (nsp < 1) st = tsm_pkg::ST_UNDERFLOW;
        else if (pos < 0 || pos >= nsp - 1) st = tsm_pkg::ST_INDEX;
        else begin
          stk_val[pos] = stk_val[nsp-1]; stk_tag[pos] = stk_tag[nsp-1]; nsp--;
        end
      end
      tsm_pkg::OP_PUSHSP, tsm_pkg::OP_PUSHFP, tsm_pkg::OP_PUSHGP: begin
        if (nsp >= tsm_pkg::STACK_DEPTH) st = tsm_pkg::ST_OVERFLOW;
        else begin
          r = (it.op == tsm_pkg::OP_PUSHSP) ? 32'(sp_r) :
              (it.op == tsm_pkg::OP_PUSHFP) ? 32'(fp_r) : 32'd0;
          stk_val[nsp] = r; stk_tag[nsp] = tsm_pkg::TAG_STACK; nsp++;
        end
      end
      tsm_pkg::OP_JUMP: npc = it.tgt;
      tsm_pkg::OP_JZ: begin
        if (nsp < 1) st = tsm_pkg::ST_UNDERFLOW;
        else if (stk_tag[nsp-1] != tsm_pkg::TAG_INT) st = tsm_pkg::ST_TYPE;
        else begin
          if (stk_val[nsp-1] == 0) npc = it.tgt;
          nsp--;
        end
      end
      tsm_pkg::OP_PUSHA: begin
        if (nsp >= tsm_pkg::STACK_DEPTH) st = tsm_pkg::ST_OVERFLOW;
        else begin
          stk_val[nsp] = {16'd0, it.tgt}; stk_tag[nsp] = tsm_pkg::TAG_CODE; nsp++;
        end
      end
      tsm_pkg::OP_CALL: begin
        if (nsp < 1) st = tsm_pkg::ST_UNDERFLOW;
        else if (stk_tag[nsp-1] != tsm_pkg::TAG_CODE) st = tsm_pkg::ST_TYPE;
        else if (depth >= tsm_pkg::CALL_DEPTH) st = tsm_pkg::ST_CALL;
        else begin
          ret_pc[depth] = npc;
          ret_fp[depth] = fp_r;
          depth++;
          npc = stk_val[nsp-1][15:0];
          nsp--;
          nfp = nsp;
        end
      end
      tsm_pkg::OP_RETURN: begin
        if (depth == 0) st = tsm_pkg::ST_CALL;
        else begin
          depth--;
          nsp = fp_r;
          npc = ret_pc[depth];
          nfp = ret_fp[depth];
        end
      end
      tsm_pkg::OP_START: nfp = nsp;
      tsm_pkg::OP_NOP:   npc = pc_r;
      default: begin
        if (nsp < 1) st = tsm_pkg::ST_UNDERFLOW;
        else begin
          nsp--;
          wv = 1'b1;
          wval = stk_val[nsp];
          wtag = stk_tag[nsp];
        end
      end
    endcase

    // Commit registers only on success
    if (st == tsm_pkg::ST_OK) begin
      pc_r = npc;
      sp_r = nsp;
      fp_r = nfp;
    end else begin
      wv = 1'b0;
    end
    if (!wv && sp_r > 0) begin
      wval = stk_val[sp_r-1];
      wtag = stk_tag[sp_r-1];
    end else if (!wv) begin
      wval = '0;
      wtag = tsm_pkg::TAG_INT;
    end
    res.status      = st;
    res.top_value   = wval;
    res.top_type    = wtag;
    res.stack_empty = (sp_r == 0);
    res.pc          = pc_r;
    res.sp          = 9'(sp_r);
    res.fp          = 9'(fp_r);
    res.write_valid = wv;
  endtask

  // Queue one request
  task automatic add(input tsm_pkg::op_t op, input logic [31:0] imm,
                     input logic [15:0] tgt);
    instr_t it;
    it.op  = op;
    it.imm = imm;
    it.tgt = tgt;
    pending_q.push_back(it);
  endtask

  // Operand value biased toward small numbers and the extremes
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return $urandom;
      1: return 32'h8000_0000;
      2: return 32'h7fff_ffff;
      3: return 32'hffff_ffff;
      4: return 32'd0;
      default: return 32'($urandom_range(0, 20)) - 32'd10;
    endcase
  endfunction

  // Stack offset or count, mostly small
  function automatic logic [31:0] pick_offset();
    if ($urandom_range(0, 19) == 0) return $urandom;
    return 32'($urandom_range(0, 11)) - 32'd2;
  endfunction

  // Driver: hold the request until accepted, then advance
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        step_res_t res;
        execute_step(cur_instr, res);
        expected_q.push_back(res);
        accepted <= accepted + 1;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (pending_q.size() > 0 && $urandom_range(0, 99) >= send_idle) begin
          cur_instr = pending_q.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.req_type <= cur_instr.op;
          req_ch.imm      <= cur_instr.imm;
          req_ch.target   <= cur_instr.tgt;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Idle phases: none, sender idle, receiver stall, both
  always_comb begin
    case ((accepted * 4) / NUM_ITEMS)
      0:       begin send_idle = 0;  recv_stall = 0;  end
      1:       begin send_idle = 65; recv_stall = 0;  end
      2:       begin send_idle = 0;  recv_stall = 65; end
      default: begin send_idle = 16; recv_stall = 16; end
    endcase
  end

  // Monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      rsp_ch.ready <= ($urandom_range(0, 99) >= recv_stall);
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_q.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          step_res_t e;
          e = expected_q.pop_front();
          if (rsp_ch.status !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, rsp_ch.status); errors++;
          end
          if (rsp_ch.top_value !== e.top_value) begin
            $error("top_value: expected %h, got %h", e.top_value, rsp_ch.top_value); errors++;
          end
          if (rsp_ch.top_type !== e.top_type) begin
            $error("top_type: expected %0d, got %0d", e.top_type, rsp_ch.top_type); errors++;
          end
          if (rsp_ch.stack_empty !== e.stack_empty) begin
            $error("stack_empty: expected %0d, got %0d", e.stack_empty, rsp_ch.stack_empty);
            errors++;
          end
          if (rsp_ch.pc_out !== e.pc) begin
            $error("pc_out: expected %0d, got %0d", e.pc, rsp_ch.pc_out); errors++;
          end
          if (rsp_ch.sp_out !== e.sp) begin
            $error("sp_out: expected %0d, got %0d", e.sp, rsp_ch.sp_out); errors++;
          end
          if (rsp_ch.fp_out !== e.fp) begin
            $error("fp_out: expected %0d, got %0d", e.fp, rsp_ch.fp_out); errors++;
          end
          if (rsp_ch.write_valid !== e.write_valid) begin
            $error("write_valid: expected %0d, got %0d", e.write_valid, rsp_ch.write_valid);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog: end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("typed_stack_machine_exec test failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run
  initial begin
    int kind;
    int cnt;
    rst = 1'b1;
    req_ch.valid = 1'b0;
    req_ch.req_type = tsm_pkg::OP_NOP;
    req_ch.imm = '0;
    req_ch.target = '0;
    rsp_ch.ready = 1'b0;
    accepted = 0;
    errors = 0;
    idle_cycles = 0;
    depth = 0;
    pc_r = '0;
    sp_r = 0;
    fp_r = 0;

    // Directed corner cases
    add(tsm_pkg::OP_WRITE, 0, 0);                    // underflow on empty stack
    add(tsm_pkg::OP_RETURN, 0, 0);                   // empty call stack
    add(tsm_pkg::OP_PUSHI, 32'h7fff_ffff, 0);
    add(tsm_pkg::OP_PUSHI, 32'd1, 0);
    add(tsm_pkg::OP_ADD, 0, 0);                      // wraps to most negative
    add(tsm_pkg::OP_PUSHI, 32'hffff_ffff, 0);
    add(tsm_pkg::OP_DIV, 0, 0);                      // most negative by -1
    add(tsm_pkg::OP_PUSHI, 32'hffff_ffff, 0);
    add(tsm_pkg::OP_MOD, 0, 0);                      // remainder of that is zero
    add(tsm_pkg::OP_PUSHI, 32'd0, 0);
    add(tsm_pkg::OP_DIV, 0, 0);                      // divide by zero
    add(tsm_pkg::OP_PUSHA, 32'd0, 16'hffff);
    add(tsm_pkg::OP_ADD, 0, 0);                      // type mismatch
    add(tsm_pkg::OP_PADD, 0, 0);
    add(tsm_pkg::OP_CALL, 0, 0);
    add(tsm_pkg::OP_JUMP, 0, 16'hffff);
    add(tsm_pkg::OP_PUSHI, 32'd3, 0);                // pc wraps past the top
    add(tsm_pkg::OP_PUSHN, 32'h7fff_ffff, 0);        // count too large
    add(tsm_pkg::OP_POPIMM, 32'h8000_0000, 0);       // negative count does nothing
    add(tsm_pkg::OP_PUSHG, 32'hffff_ffff, 0);        // index out of range
    add(tsm_pkg::OP_PUSHL, 32'd0, 0);
    add(tsm_pkg::OP_START, 0, 0);
    add(tsm_pkg::OP_NOP, 0, 0);
    add(tsm_pkg::OP_RETURN, 0, 0);
    add(tsm_pkg::OP_POPIMM, 32'd1000, 0);            // underflow
    add(tsm_pkg::OP_PUSHGP, 0, 0);

    // Random instruction sequences
    while (pending_q.size() < NUM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 28) begin
        add(tsm_pkg::OP_PUSHI, pick_value(), 0);
        add(tsm_pkg::OP_PUSHI, pick_value(), 0);
        add(tsm_pkg::op_t'($urandom_range(tsm_pkg::OP_ADD, tsm_pkg::OP_EQUAL)), 0, 0);
      end else if (kind < 40) begin
        add(tsm_pkg::OP_PUSHA, 0, 16'($urandom_range(0, 65535)));
        add(tsm_pkg::OP_CALL, 0, 0);
        add(tsm_pkg::OP_PUSHI, pick_value(), 0);
        add(tsm_pkg::OP_PUSHI, pick_value(), 0);
        add(tsm_pkg::OP_PUSHL, pick_offset(), 0);
        add(tsm_pkg::OP_STOREL, pick_offset(), 0);
        if ($urandom_range(0, 3) != 0) add(tsm_pkg::OP_RETURN, 0, 0);
      end else if (kind < 50) begin
        add(tsm_pkg::OP_PUSHI, pick_value(), 0);
        add(tsm_pkg::OP_PUSHG, pick_offset(), 0);
        add(tsm_pkg::OP_STOREG, pick_offset(), 0);
      end else if (kind < 58) begin
        add(tsm_pkg::OP_PUSHN, pick_offset(), 0);
        add(tsm_pkg::OP_PUSHI, pick_offset(), 0);
        add(tsm_pkg::OP_POPN, 0, 0);
        add(tsm_pkg::OP_POPIMM, pick_offset(), 0);
      end else if (kind < 66) begin
        add(tsm_pkg::op_t'($urandom_range(tsm_pkg::OP_PUSHSP, tsm_pkg::OP_PUSHGP)), 0, 0);
        if ($urandom_range(0, 1)) add(tsm_pkg::OP_PUSHA, 0, 16'($urandom_range(0, 65535)));
        add(tsm_pkg::OP_PUSHI, pick_value(), 0);
        if ($urandom_range(0, 1)) add(tsm_pkg::OP_SWAP, 0, 0);
        add(tsm_pkg::OP_PADD, 0, 0);
      end else if (kind < 72) begin
        add(tsm_pkg::OP_PUSHI, 32'($urandom_range(0, 1)), 0);
        add(tsm_pkg::OP_JZ, 0, 16'($urandom_range(0, 65535)));
        add(tsm_pkg::OP_JUMP, 0, 16'($urandom_range(0, 65535)));
      end else if (kind < 78) begin
        add(tsm_pkg::OP_WRITE, 0, 0);
        add(tsm_pkg::op_t'($urandom_range(0, 1) ? tsm_pkg::OP_START : tsm_pkg::OP_NOP),
            0, 0);
        add(tsm_pkg::OP_NOT, 0, 0);
      end else if (kind < 82) begin
        // Deep call chain, possibly past the call stack size
        cnt = $urandom_range(1, 34);
        for (int i = 0; i < cnt; i++) begin
          add(tsm_pkg::OP_PUSHA, 0, 16'($urandom_range(0, 65535)));
          add(tsm_pkg::OP_CALL, 0, 0);
        end
        cnt = $urandom_range(1, 34);
        for (int i = 0; i < cnt; i++) add(tsm_pkg::OP_RETURN, 0, 0);
      end else if (kind < 85) begin
        // Fill the stack to the top
        add(tsm_pkg::OP_POPIMM, 32'd300, 0);
        add(tsm_pkg::OP_PUSHN, 32'($urandom_range(200, 256)), 0);
        add(tsm_pkg::OP_PUSHN, 32'($urandom_range(1, 60)), 0);
        add(tsm_pkg::op_t'($urandom_range(0, 1) ? tsm_pkg::OP_PUSHI : tsm_pkg::OP_PUSHSP),
            pick_value(), 0);
        add(tsm_pkg::OP_PUSHG, 32'($urandom_range(0, 255)), 0);
        add(tsm_pkg::OP_POPIMM, 32'($urandom_range(0, 256)), 0);
      end else begin
        add(tsm_pkg::op_t'($urandom_range(0, 31)),
            $urandom_range(0, 1) ? $urandom : pick_offset(),
            16'($urandom_range(0, 65535)));
      end
    end

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Drain: all requests sent and all results seen
    do @(posedge clk);
    while (pending_q.size() > 0 || req_ch.valid || expected_q.size() > 0);
    repeat (400) @(posedge clk);

    if (errors == 0 && expected_q.size() == 0) begin
      $display("typed_stack_machine_exec test passed");
    end else begin
      $display("typed_stack_machine_exec test failed");
    end
    $finish;
  end

endmodule
